// ===== hw/rtl/sobel_magnitude_direction_macros.svh =====
// ----------------------------------------------------------------------------
// sobel magnitude/direction assertion macros
// shared concurrent assertion forms for the block
// ----------------------------------------------------------------------------
`ifndef SOBEL_MAGNITUDE_DIRECTION_MACROS_SVH
`define SOBEL_MAGNITUDE_DIRECTION_MACROS_SVH

// same-cycle implication
`define SMD_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define SMD_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg
// types, constants and the arctangent table of the sobel block
// ----------------------------------------------------------------------------
package smd_pkg;

	localparam int PIXEL_BITS      = 8;
	localparam int ANGLE_FRAC_BITS = 10;
	localparam int MAG_W           = 9;
	localparam int DIR_W           = ANGLE_FRAC_BITS + 1;
	localparam int GRAD_W          = 11;
	localparam int CFG_W           = 11;
	localparam int ROW_W           = 11;
	localparam int CORDIC_STEPS    = 40;
	localparam int CORDIC_W        = 44;
	localparam int ANGLE_W         = 40;
	localparam int SQRT_BITS       = 9;
	localparam int STEP_W          = 6;
	localparam int HEIGHT_MAX      = 1024;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		K_IGNORE,
		K_ADVANCE,
		K_FINAL
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_INIT,
		ST_ITER,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              accept;
		logic              decide;
		logic              init;
		logic              iter;
		logic              finish;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic  clear_done;
		kind_t kind;
		logic  emit;
		logic  out_free;
	} status_t;

	typedef logic [ANGLE_W-1:0] atan_tab_t [CORDIC_STEPS];

	// floor(atan(2^-i) * 2^40) from integer series
	function automatic atan_tab_t build_atan();
		atan_tab_t       tab;
		longint unsigned sum;
		longint unsigned t;
		longint unsigned p;
		int              e;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			sum = 0;
			if (i == 0) begin
				for (int k = 0; k < 32; k++) begin
					e = 60 - (2 * k + 1);
					if (e >= 0) begin
						t = (64'd1 << e) / 64'(2 * k + 1);
						sum = (k % 2 == 1) ? sum - t : sum + t;
					end
				end
				p = (64'd1 << 60) / 64'd3;
				for (int k = 0; k < 64; k++) begin
					if (p != 0) begin
						t = p / 64'(2 * k + 1);
						sum = (k % 2 == 1) ? sum - t : sum + t;
						p = p / 64'd9;
					end
				end
			end else begin
				for (int k = 0; k < 32; k++) begin
					e = 60 - i * (2 * k + 1);
					if (e >= 0) begin
						t = (64'd1 << e) / 64'(2 * k + 1);
						sum = (k % 2 == 1) ? sum - t : sum + t;
					end
				end
			end
			tab[i] = ANGLE_W'(sum >> 20);
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

// ===== hw/rtl/smd_ram.sv =====
// ----------------------------------------------------------------------------
// smd_ram
// generic simple dual-port ram, registered read
// ----------------------------------------------------------------------------
module smd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/smd_ctrl.sv =====
// ----------------------------------------------------------------------------
// smd_ctrl
// sequencer: clearing pass, item decode, cordic/sqrt iterations, output load
// ----------------------------------------------------------------------------
`include "sobel_magnitude_direction_macros.svh"

module smd_ctrl
	import smd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (status.clear_done) state_d = ST_IDLE;
			ST_IDLE:   if (s_tvalid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (status.kind != K_IGNORE && status.emit) state_d = ST_INIT;
				else state_d = ST_IDLE;
			end
			ST_INIT:   state_d = ST_ITER;
			ST_ITER:   if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_d = ST_DONE;
			ST_DONE:   if (status.out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.accept = (state_q == ST_IDLE) && s_tvalid;
		cmd.decide = (state_q == ST_DECIDE);
		cmd.init   = (state_q == ST_INIT);
		cmd.iter   = (state_q == ST_ITER);
		cmd.finish = (state_q == ST_DONE) && status.out_free;
		cmd.step   = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ITER) step_q <= step_q + STEP_W'(1);
			else step_q <= '0;
		end
	end

	`SMD_ASSERT_NXT(a_accept_decide, clk, arst_n, cmd.accept, state_q == ST_DECIDE, "accept not followed by decode")
	`SMD_ASSERT_IMP(a_step_range, clk, arst_n, state_q == ST_ITER, step_q < STEP_W'(CORDIC_STEPS), "step beyond cordic length")
	`SMD_ASSERT_IMP(a_finish_free, clk, arst_n, cmd.finish, status.out_free, "output loaded while occupied")

endmodule

// ===== hw/rtl/smd_datapath.sv =====
// ----------------------------------------------------------------------------
// smd_datapath
// line stores, 3x3 window, gradients, iterative sqrt and cordic, output beat
// ----------------------------------------------------------------------------
module smd_datapath
	import smd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [PIXEL_BITS-1:0] s_tdata,
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,
	output logic                  m_tlast
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
	localparam logic [DIR_W-1:0] ONE = DIR_W'(1 << ANGLE_FRAC_BITS);
	localparam logic [CORDIC_W-1:0] HALF = CORDIC_W'(1) << (39 - ANGLE_FRAC_BITS);

	typedef logic [PIXEL_BITS-1:0] px_t;

	logic [CFG_W-1:0] fw_q, fh_q;
	logic [CW-1:0]    col_q, sweep_q;
	logic [ROW_W-1:0] row_q;
	logic             cmd_q, last_q;
	px_t              pix_q;
	px_t              win_q [3][3];
	px_t              top, mid, pin;
	px_t              nw [3][3];
	px_t              wn [3][3];
	px_t              wr [3][3];
	px_t              ws [3][3];
	logic [12:0]      wclamp;
	logic [ROW_W-1:0] hclamp;
	logic [12:0]      col_inc;
	kind_t            kind;
	logic             emit;
	logic [9:0]       sum_top, sum_bot, sum_lft, sum_rgt;
	logic signed [GRAD_W-1:0] ga, gb, a_q, b_q, ma, mb;
	logic [PIXEL_BITS-1:0]    ca, cb;
	logic [16:0]      s_q;
	logic [SQRT_BITS-1:0] r_q, t;
	logic [17:0]      tt;
	logic [16:0]      rr;
	logic signed [CORDIC_W-1:0] x_q, y_q, z_q, dx, dy, ang;
	logic             spec_q;
	logic [DIR_W-1:0] spec_dir_q, dir;
	logic [CORDIC_W-1:0] zr;
	logic [13:0]      dsh;
	logic [MAG_W-1:0] mag_q_out;
	logic [DIR_W-1:0] dir_q_out;
	logic             valid_q;
	logic             we_ram;
	logic [CW-1:0]    waddr;
	px_t              wd_up, wd_lo;

	// line stores
	smd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(we_ram), .waddr(waddr), .wdata(wd_up),
		.re(cmd.accept), .raddr(col_q), .rdata(top)
	);
	smd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_lower (
		.clk(clk), .we(we_ram), .waddr(waddr), .wdata(wd_lo),
		.re(cmd.accept), .raddr(col_q), .rdata(mid)
	);

	// geometry and item decode
	always_comb begin
		wclamp = (13'(fw_q) < 13'd3) ? 13'd3 : ((13'(fw_q) > MAXW) ? MAXW : 13'(fw_q));
		hclamp = (fh_q < 11'd3) ? 11'd3 : ((fh_q > 11'(HEIGHT_MAX)) ? 11'(HEIGHT_MAX) : fh_q);
		col_inc = 13'(col_q) + 13'd1;
		if (!cmd_q) kind = (row_q >= hclamp) ? K_IGNORE : K_ADVANCE;
		else if (row_q < hclamp) kind = K_IGNORE;
		else if (12'(row_q) >= 12'(hclamp) + 12'd1) kind = K_FINAL;
		else kind = K_ADVANCE;
		emit = (kind == K_FINAL) || (col_q == '0 && row_q >= 11'd2) ||
			(col_q != '0 && row_q >= 11'd1);
		status.clear_done = (sweep_q == CW'(MAX_WIDTH - 1));
		status.kind       = kind;
		status.emit       = emit;
		status.out_free   = !valid_q || m_tready;
	end

	always_comb begin
		pin = cmd_q ? '0 : pix_q;
		we_ram = cmd.clear || (cmd.decide && kind == K_ADVANCE);
		waddr  = cmd.clear ? sweep_q : col_q;
		wd_up  = cmd.clear ? '0 : mid;
		wd_lo  = cmd.clear ? '0 : pin;
	end

	// window selection
	always_comb begin
		nw[0] = win_q[1];
		nw[1] = win_q[2];
		nw[2][0] = top;
		nw[2][1] = mid;
		nw[2][2] = pin;
		wn = nw;
		if (col_q == CW'(1)) begin
			wn[0] = '{default: '0};
		end
		if (row_q < 11'd2) begin
			for (int j = 0; j < 3; j++) wn[j][0] = '0;
		end
		wr[0] = win_q[1];
		wr[1] = win_q[2];
		wr[2] = '{default: '0};
		if (row_q < 11'd3) begin
			wr[0][0] = '0;
			wr[1][0] = '0;
		end
		ws = (kind == K_FINAL || col_q == '0) ? wr : wn;
		sum_bot = 10'(ws[0][2]) + {1'b0, ws[1][2], 1'b0} + 10'(ws[2][2]);
		sum_top = 10'(ws[0][0]) + {1'b0, ws[1][0], 1'b0} + 10'(ws[2][0]);
		sum_lft = 10'(ws[0][0]) + {1'b0, ws[0][1], 1'b0} + 10'(ws[0][2]);
		sum_rgt = 10'(ws[2][0]) + {1'b0, ws[2][1], 1'b0} + 10'(ws[2][2]);
		ga = $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
		gb = $signed({1'b0, sum_lft}) - $signed({1'b0, sum_rgt});
	end

	// clamps, sqrt and cordic step
	always_comb begin
		ca = a_q[GRAD_W-1] ? '0 : ((|a_q[9:8]) ? 8'hFF : a_q[7:0]);
		cb = b_q[GRAD_W-1] ? '0 : ((|b_q[9:8]) ? 8'hFF : b_q[7:0]);
		ma = (!a_q[GRAD_W-1] && |a_q[9:8]) ? 11'sd255 : a_q;
		mb = (!b_q[GRAD_W-1] && |b_q[9:8]) ? 11'sd255 : b_q;
		t  = r_q | (SQRT_BITS'(1) << (4'd8 - cmd.step[3:0]));
		tt = 18'(t) * 18'(t);
		rr = 17'(r_q) * 17'(r_q) + 17'(r_q);
		dx = y_q >>> cmd.step;
		dy = x_q >>> cmd.step;
		ang = $signed({4'b0, ATAN_TAB[cmd.step]});
		zr  = CORDIC_W'(z_q) + HALF;
		dsh = 14'(zr >> (40 - ANGLE_FRAC_BITS));
		if (spec_q) dir = spec_dir_q;
		else if (z_q[CORDIC_W-1]) dir = '0;
		else if (dsh > 14'(ONE)) dir = ONE;
		else dir = dsh[DIR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= 11'd640;
			fh_q    <= 11'd480;
			col_q   <= '0;
			row_q   <= '0;
			sweep_q <= '0;
			valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  fw_q <= cfg_data;
					REG_FRAME_HEIGHT: fh_q <= cfg_data;
				endcase
			end
			if (cmd.clear) sweep_q <= sweep_q + CW'(1);
			if (cmd.decide && kind == K_ADVANCE) begin
				win_q <= nw;
				if (col_inc >= wclamp) begin
					col_q <= '0;
					row_q <= row_q + 11'd1;
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
			if (cmd.decide && kind == K_FINAL) begin
				col_q <= '0;
				row_q <= '0;
			end
			if (cmd.finish) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= s_tuser;
			pix_q <= s_tdata;
		end
		if (cmd.decide) begin
			a_q    <= ga;
			b_q    <= gb;
			last_q <= (kind == K_FINAL);
		end
		if (cmd.init) begin
			s_q   <= 17'(ca) * 17'(ca) + 17'(cb) * 17'(cb);
			r_q   <= '0;
			x_q   <= $signed({4'b0, ma[7:0], 32'b0});
			y_q   <= $signed({4'b0, mb[7:0], 32'b0});
			z_q   <= '0;
			spec_q <= mb[GRAD_W-1] || (mb == '0) || ma[GRAD_W-1] || (ma == '0);
			if (mb[GRAD_W-1]) spec_dir_q <= '0;
			else if (mb == '0) spec_dir_q <= ma[GRAD_W-1] ? ONE : '0;
			else spec_dir_q <= ONE;
		end
		if (cmd.iter) begin
			if (cmd.step < STEP_W'(SQRT_BITS)) begin
				if (tt <= 18'(s_q)) r_q <= t;
			end else if (cmd.step == STEP_W'(SQRT_BITS)) begin
				if (s_q > rr) r_q <= r_q + SQRT_BITS'(1);
			end
			if (!y_q[CORDIC_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end
		end
		if (cmd.finish) begin
			mag_q_out <= r_q;
			dir_q_out <= dir;
			m_tlast   <= last_q;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'b0, dir_q_out, mag_q_out};

endmodule

// ===== hw/rtl/sobel_magnitude_direction.sv =====
// flow: an accepted beat is decoded; one that yields a result then passes init,
// the 40-step shared cordic loop that also runs the 9-bit sqrt, and an output
// load that waits for a free output; no new beat is taken until it is through
// reset: asynchronous, then a clearing pass over every line-store entry,
// during which no beat is accepted; configuration writes are taken throughout
// ----------------------------------------------------------------------------
// sobel_magnitude_direction
// streamed 3x3 sobel gradient magnitude and direction
// ----------------------------------------------------------------------------
module sobel_magnitude_direction
	import smd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIXEL_BITS-1:0] s_tdata,  // pixel
	input  logic                  s_tuser,  // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,  // magnitude[8:0], direction[19:9]
	output logic                  m_tlast
);

	cmd_t    cmd;
	status_t status;

	smd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.status(status), .cmd(cmd)
	);

	smd_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

endmodule

// ===== bench/tb_sobel_magnitude_direction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_magnitude_direction
// Streams small gray frames, including clamped geometry, through the sobel
// block. Both sides stall at random. A scoreboard predicts the magnitude,
// direction and frame-end flag of every output beat and checks them in order.
// ----------------------------------------------------------------------------
module tb_sobel_magnitude_direction;
	import smd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_WAIT   = 100;

	typedef struct {
		logic [MAG_W-1:0] mag;
		logic [DIR_W-1:0] dir;
		logic             last;
	} edge_result_t;

	typedef int unsigned win_t [3][3];

	class sobel_scoreboard;
		int unsigned    upper [1024];
		int unsigned    lower [1024];
		win_t           win;
		int unsigned    col;
		int unsigned    row;
		int unsigned    width_raw;
		int unsigned    height_raw;
		longint         atan_tab [CORDIC_STEPS];
		edge_result_t   pending_q [$];
		int             mismatches;
		int             matched;

		function new();
			longint unsigned sum;
			longint unsigned t;
			longint unsigned p;
			width_raw  = 640;
			height_raw = 480;
			for (int i = 0; i < 1024; i++) begin
				upper[i] = 0;
				lower[i] = 0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win[i][j] = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				sum = 0;
				if (i == 0) begin
					for (int k = 0; 60 - (2 * k + 1) >= 0; k++) begin
						t = (64'd1 << (60 - (2 * k + 1))) / 64'(2 * k + 1);
						sum = (k % 2 == 1) ? sum - t : sum + t;
					end
					p = (64'd1 << 60) / 64'd3;
					for (int k = 0; p != 0; k++) begin
						t = p / 64'(2 * k + 1);
						sum = (k % 2 == 1) ? sum - t : sum + t;
						p = p / 64'd9;
					end
				end else begin
					for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
						t = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
						sum = (k % 2 == 1) ? sum - t : sum + t;
					end
				end
				atan_tab[i] = longint'(sum >> 20);
			end
		endfunction

		function void write_reg(logic idx, int unsigned value);
			if (idx == REG_FRAME_WIDTH)
				width_raw = value & 11'h7ff;
			else
				height_raw = value & 11'h7ff;
		endfunction

		function int unsigned eff_width();
			return width_raw < 3 ? 3 : (width_raw > 1024 ? 1024 : width_raw);
		endfunction

		function int unsigned eff_height();
			return height_raw < 3 ? 3 : (height_raw > 1024 ? 1024 : height_raw);
		endfunction

		function longint unsigned round_sqrt(longint unsigned s);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = 20; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= s)
					r = t;
			end
			if (s > r * r + r)
				r++;
			return r;
		endfunction

		function int unsigned angle_of(int a, int b);
			longint x;
			longint y;
			longint z;
			longint dx;
			longint dy;
			longint unsigned d;
			if (b < 0)
				return 0;
			if (b == 0)
				return a < 0 ? 1024 : 0;
			if (a <= 0)
				return 1024;
			x = longint'(a) <<< 32;
			y = longint'(b) <<< 32;
			z = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += atan_tab[i];
				end else begin
					x -= dx; y += dy; z -= atan_tab[i];
				end
			end
			if (z < 0)
				return 0;
			d = (longint'(z) + (64'd1 << (39 - ANGLE_FRAC_BITS))) >> (40 - ANGLE_FRAC_BITS);
			return d > 1024 ? 1024 : int'(d);
		endfunction

		function void push_result(win_t w, bit last);
			int              a;
			int              b;
			longint unsigned ca;
			longint unsigned cb;
			edge_result_t    res;
			a = int'(w[0][2] + 2 * w[1][2] + w[2][2]) - int'(w[0][0] + 2 * w[1][0] + w[2][0]);
			b = int'(w[0][0] + 2 * w[0][1] + w[0][2]) - int'(w[2][0] + 2 * w[2][1] + w[2][2]);
			ca = a < 0 ? 0 : (a > 255 ? 255 : a);
			cb = b < 0 ? 0 : (b > 255 ? 255 : b);
			res.mag  = MAG_W'(round_sqrt(ca * ca + cb * cb));
			res.dir  = DIR_W'(angle_of(a > 255 ? 255 : a, b > 255 ? 255 : b));
			res.last = last;
			pending_q.push_back(res);
		endfunction

		function void row_end(int unsigned r, bit last);
			win_t w;
			w[0] = win[1];
			w[1] = win[2];
			w[2] = '{0, 0, 0};
			if (r < 3) begin
				w[0][0] = 0;
				w[1][0] = 0;
			end
			push_result(w, last);
		endfunction

		function void shift_pixel(int unsigned p);
			int unsigned c;
			int unsigned r;
			int unsigned top;
			int unsigned mid;
			win_t        w;
			c = col;
			r = row;
			if (c >= 1024)
				c = 0;
			if (c == 0 && r >= 2)
				row_end(r, 0);
			top = upper[c];
			mid = lower[c];
			upper[c] = mid;
			lower[c] = p;
			win[0] = win[1];
			win[1] = win[2];
			win[2] = '{top, mid, p};
			if (c >= 1 && r >= 1) begin
				w = win;
				if (c == 1)
					w[0] = '{0, 0, 0};
				if (r < 2) begin
					w[0][0] = 0; w[1][0] = 0; w[2][0] = 0;
				end
				push_result(w, 0);
			end
			c++;
			if (c >= eff_width()) begin
				c = 0;
				r++;
			end
			col = c;
			row = r;
		endfunction

		function void note_input(logic drain, logic [7:0] pix);
			if (!drain) begin
				if (row < eff_height())
					shift_pixel(pix);
			end else if (row >= eff_height() + 1) begin
				row_end(row, 1);
				col = 0;
				row = 0;
			end else if (row >= eff_height()) begin
				shift_pixel(0);
			end
		endfunction

		function void check(logic [23:0] data, logic last);
			edge_result_t exp_r;
			if (pending_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected output beat data=%h last=%b", data, last);
				mismatches++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (data[8:0] !== exp_r.mag || data[19:9] !== exp_r.dir || last !== exp_r.last) begin
				if (mismatches < 10)
					$display("mismatch: exp mag=%0d dir=%0d last=%b got mag=%0d dir=%0d last=%b",
						exp_r.mag, exp_r.dir, exp_r.last, data[8:0], data[19:9], last);
				mismatches++;
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIXEL_BITS-1:0] s_tdata;   // pixel
	logic                  s_tuser;   // command
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;   // magnitude[8:0], direction[19:9]
	logic                  m_tlast;

	sobel_scoreboard sb;
	int              cycle_count;
	bit              quiet;
	bit              hold_req;
	int              hold_left;
	int              frames_run;
	int              pixel_beats;

	sobel_magnitude_direction uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_sobel_magnitude_direction failed");
			$finish;
		end
	end

	// output side: random stalls and one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata, m_tlast);
	end

	function automatic logic [7:0] gray_value();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_beat(logic drain, logic [7:0] pix);
		while (!quiet && $urandom_range(99) < 13) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= drain;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		sb.note_input(drain, pix);
		pixel_beats++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	task automatic run_frame(int unsigned w_raw, int unsigned h_raw, bit noise, bit pause_mid,
			bit fixed_pattern);
		int unsigned w;
		int unsigned h;
		logic [7:0]  pix;
		wait_idle();
		write_reg(REG_FRAME_WIDTH, w_raw);
		write_reg(REG_FRAME_HEIGHT, h_raw);
		w = sb.eff_width();
		h = sb.eff_height();
		for (int n = 0; n < w * h; n++) begin
			if (noise && $urandom_range(99) < 5)
				send_beat(1'b1, 8'($urandom));
			if (pause_mid && n == (w * h) / 2) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				while (sb.pending_q.size() != 0)
					@(posedge clk);
			end
			pix = fixed_pattern ? (((n / w + n % w) % 2 == 0) ? 8'd255 : 8'd0) : gray_value();
			send_beat(1'b0, pix);
		end
		if (noise && $urandom_range(1))
			send_beat(1'b0, 8'($urandom));
		for (int n = 0; n <= w; n++)
			send_beat(1'b1, 8'($urandom));
		frames_run++;
	endtask

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_FRAME_WIDTH;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		quiet       = 0;
		hold_req    = 0;
		hold_left   = 0;
		cycle_count = 0;
		frames_run  = 0;
		pixel_beats = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: checkerboard and extreme values at and near minimum geometry
		run_frame(3, 3, 0, 0, 1);
		run_frame(4, 3, 0, 0, 0);
		run_frame(3, 4, 1, 0, 1);

		// long stretch with no idling on either side
		quiet = 1;
		run_frame(12, 8, 0, 0, 0);
		quiet = 0;

		// out-of-range geometry clamped to the minimum
		run_frame(0, 2, 0, 0, 0);
		run_frame(1, 0, 1, 0, 0);

		// random small frames
		while (pixel_beats < 700) begin
			if (frames_run == 7)
				hold_req = 1;
			run_frame($urandom_range(3, 12), $urandom_range(3, 8), $urandom_range(1),
				frames_run == 9, 0);
		end

		wait_idle();
		$display("ran %0d frames, %0d input beats, %0d output beats matched",
			frames_run, pixel_beats, sb.matched);
		$display("small and clamped frame sizes with stray beats, both sides stalled");
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("tb_sobel_magnitude_direction passed");
		end else begin
			$display("tb_sobel_magnitude_direction failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/smd_pkg.sv
hw/rtl/smd_ram.sv
hw/rtl/smd_ctrl.sv
hw/rtl/smd_datapath.sv
hw/rtl/sobel_magnitude_direction.sv
bench/tb_sobel_magnitude_direction.sv
